// ===== hdl/uf_pkg.sv =====
// Shared types, widths and codes for the union-find engine.
package uf_pkg;

  localparam int NODE_W        = 10;
  localparam int SIZE_W        = 11;
  localparam int RANK_W        = 4;
  localparam int NODES_DEFAULT = 1024;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 2;

  typedef logic [1:0]          cmd_t;
  typedef logic [1:0]          status_t;
  typedef logic [1:0]          mode_t;
  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [RANK_W-1:0]   rank_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Commands
  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_FIND   = 2'd1;
  localparam cmd_t CMD_LINK   = 2'd2;

  // Result status
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_ABSENT  = 2'd1;
  localparam status_t ST_SAME    = 2'd2;
  localparam status_t ST_PRESENT = 2'd3;

  // Merge rule
  localparam mode_t LINK_SIZE  = 2'd0;
  localparam mode_t LINK_RANK  = 2'd1;

  // Find rule
  localparam mode_t FIND_FULL  = 2'd0;
  localparam mode_t FIND_HALVE = 2'd1;

  // Configuration register indexes
  localparam cfg_idx_t CFG_LINK_MODE = 2'd0;
  localparam cfg_idx_t CFG_FIND_MODE = 2'd1;

  localparam rank_t RANK_MAX = 4'd15;

  // One table entry per node
  typedef struct packed {
    logic  present;
    node_t parent;
    size_t size;
    rank_t rank;
  } entry_t;

endpackage

// ===== hdl/uf_req_if.sv =====
// Request channel: command and node indexes.
interface uf_req_if;
  import uf_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  node_t node_a;
  node_t node_b;

  modport source (output valid, output command, output node_a, output node_b, input ready);
  modport sink   (input valid, input command, input node_a, input node_b, output ready);
endinterface

// ===== hdl/uf_rsp_if.sv =====
// Response channel: root index and status.
interface uf_rsp_if;
  import uf_pkg::*;

  logic    valid;
  logic    ready;
  node_t   root;
  status_t status;

  modport source (output valid, output root, output status, input ready);
  modport sink   (input valid, input root, input status, output ready);
endinterface

// ===== hdl/uf_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface uf_cfg_if;
  import uf_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/union_find_engine.sv =====
// Disjoint-set engine: node table in one memory, walked by a small sequencer.
//
// Usage: commands arrive on req (insert, find, link of node_a / node_b), one
// response per command leaves on rsp (a status code and the root of node_a,
// or after a merge the surviving root). The cfg channel writes link_mode
// (index 0) and find_mode (index 1); it is always ready and should only be
// written while no command is in flight.
// Flow: one command at a time; req.ready is high only in the idle state.
// Every table read goes through the one read port of the node memory, so
// cost follows the tree depth d of the node walked:
//   insert: one write for a new node, a root walk for a present one.
//   find: a root walk, then full compression or path halving if so set.
//   link: two finds, then the root compare and merge.
// The result then moves into the output register.
// Reset: a clearing pass over all NODES entries marks every node absent; req is
// not ready during it. Config writes are taken whenever rst is low.
// Stall: the result waits in an output register; a second finished result
// waits in the engine until rsp.ready frees that register.
module union_find_engine #(
  parameter int NODES = uf_pkg::NODES_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  uf_req_if.sink   req,
  uf_rsp_if.source rsp,
  uf_cfg_if.sink   cfg
);
  import uf_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_WALK = 4'd3;
  localparam logic [3:0] S_FC   = 4'd4;
  localparam logic [3:0] S_HRD  = 4'd5;
  localparam logic [3:0] S_HP   = 4'd6;
  localparam logic [3:0] S_HGP  = 4'd7;
  localparam logic [3:0] S_HG   = 4'd8;
  localparam logic [3:0] S_HC   = 4'd9;
  localparam logic [3:0] S_BGO  = 4'd10;
  localparam logic [3:0] S_LA   = 4'd11;
  localparam logic [3:0] S_LB   = 4'd12;
  localparam logic [3:0] S_LH   = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  function automatic logic [AW-1:0] addr_of(input node_t n);
    return AW'(n);
  endfunction

  function automatic logic node_ok(input node_t n);
    return 32'(n) < 32'(NODES);
  endfunction

  // Registers
  logic [3:0]    state, state_next;
  logic [AW-1:0] clr_cnt, clr_cnt_next;
  cmd_t          cmd, cmd_next;
  node_t         na, na_next, nb, nb_next;
  logic          side, side_next;
  node_t         cur, cur_next;
  node_t         rt, rt_next;
  size_t         moved, moved_next;
  entry_t        ent, ent_next, aux, aux_next;
  node_t         nxt, nxt_next;
  logic          la, la_next;
  node_t         ra, ra_next;
  node_t         res_root, res_root_next;
  status_t       res_status, res_status_next;
  logic          out_valid, out_valid_next;
  node_t         out_root, out_root_next;
  status_t       out_status, out_status_next;
  mode_t         link_mode, find_mode;

  // Memory port signals
  entry_t        tbl [NODES];
  entry_t        rd_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  // Scratch
  logic   fd;
  node_t  fd_root;
  node_t  x_node;
  entry_t nd;
  logic   a_under_b;
  rank_t  child_rank;

  assign x_node    = side ? nb : na;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid  = out_valid;
  assign rsp.root   = out_root;
  assign rsp.status = out_status;

  // Node table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= tbl[rd_addr];
    end
  end

  // Sequencer next state
  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    cmd_next        = cmd;
    na_next         = na;
    nb_next         = nb;
    side_next       = side;
    cur_next        = cur;
    rt_next         = rt;
    moved_next      = moved;
    ent_next        = ent;
    aux_next        = aux;
    nxt_next        = nxt;
    la_next         = la;
    ra_next         = ra;
    res_root_next   = res_root;
    res_status_next = res_status;
    out_valid_next  = out_valid && !rsp.ready;
    out_root_next   = out_root;
    out_status_next = out_status;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    fd              = 1'b0;
    fd_root         = rt;
    nd              = rd_data;
    a_under_b       = 1'b1;
    child_rank      = '0;

    unique case (state)
      S_CLR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_cnt;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == AW'(NODES - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req.valid) begin
          cmd_next  = req.command;
          na_next   = req.node_a;
          nb_next   = req.node_b;
          side_next = 1'b0;
          la_next   = 1'b0;
          ra_next   = '0;
          cur_next  = req.node_a;
          if ((req.command == CMD_INSERT || req.command == CMD_FIND ||
               req.command == CMD_LINK) && node_ok(req.node_a)) begin
            rd_en      = 1'b1;
            rd_addr    = addr_of(req.node_a);
            state_next = S_CHK;
          end else if (req.command == CMD_LINK) begin
            state_next = S_BGO;
          end else begin
            res_root_next   = '0;
            res_status_next = ST_ABSENT;
            state_next      = S_DONE;
          end
        end
      end

      // rd_data holds the entry of the node named by the command
      S_CHK: begin
        if (!rd_data.present) begin
          if (cmd == CMD_LINK) begin
            if (!side) begin
              state_next = S_BGO;
            end else begin
              res_root_next   = ra;
              res_status_next = ST_ABSENT;
              state_next      = S_DONE;
            end
          end else if (cmd == CMD_INSERT) begin
            wr_en           = 1'b1;
            wr_addr         = addr_of(na);
            wr_data         = '{present: 1'b1, parent: na, size: SIZE_W'(1), rank: '0};
            res_root_next   = na;
            res_status_next = ST_OK;
            state_next      = S_DONE;
          end else begin
            res_root_next   = '0;
            res_status_next = ST_ABSENT;
            state_next      = S_DONE;
          end
        end else begin
          if (cmd == CMD_LINK && !side) begin
            la_next = 1'b1;
          end
          state_next = S_WALK;
        end
      end

      // Root walk: one level per cycle
      S_WALK: begin
        if (rd_data.parent == cur) begin
          rt_next = cur;
          if (cmd != CMD_INSERT && find_mode == FIND_FULL) begin
            moved_next = '0;
            cur_next   = x_node;
            rd_en      = 1'b1;
            rd_addr    = addr_of(x_node);
            state_next = S_FC;
          end else if (cmd != CMD_INSERT && find_mode == FIND_HALVE) begin
            cur_next   = x_node;
            rd_en      = 1'b1;
            rd_addr    = addr_of(x_node);
            state_next = S_HRD;
          end else begin
            fd      = 1'b1;
            fd_root = cur;
          end
        end else begin
          cur_next = rd_data.parent;
          rd_en    = 1'b1;
          rd_addr  = addr_of(rd_data.parent);
        end
      end

      // Full compression: repoint each node to the root, fix sizes on the way
      S_FC: begin
        nd.parent  = rt;
        nd.size    = rd_data.size - moved;
        wr_en      = 1'b1;
        wr_addr    = addr_of(cur);
        wr_data    = nd;
        moved_next = rd_data.size;
        if (rd_data.parent == rt) begin
          fd = 1'b1;
        end else begin
          cur_next = rd_data.parent;
          rd_en    = 1'b1;
          rd_addr  = addr_of(rd_data.parent);
        end
      end

      // Path halving: ent holds the current node's entry
      S_HRD: begin
        ent_next   = rd_data;
        state_next = S_HP;
      end

      S_HP: begin
        if (ent.parent == rt) begin
          fd = 1'b1;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = addr_of(ent.parent);
          state_next = S_HGP;
        end
      end

      S_HGP: begin
        nd.size    = rd_data.size - ent.size;
        wr_en      = 1'b1;
        wr_addr    = addr_of(ent.parent);
        wr_data    = nd;
        nxt_next   = rd_data.parent;
        rd_en      = 1'b1;
        rd_addr    = addr_of(rd_data.parent);
        state_next = S_HG;
      end

      S_HG: begin
        nd.size    = rd_data.size + ent.size;
        wr_en      = 1'b1;
        wr_addr    = addr_of(nxt);
        wr_data    = nd;
        aux_next   = nd;
        state_next = S_HC;
      end

      S_HC: begin
        nd         = ent;
        nd.parent  = nxt;
        wr_en      = 1'b1;
        wr_addr    = addr_of(cur);
        wr_data    = nd;
        cur_next   = nxt;
        ent_next   = aux;
        state_next = S_HP;
      end

      // Second node of a link
      S_BGO: begin
        side_next = 1'b1;
        cur_next  = nb;
        if (node_ok(nb)) begin
          rd_en      = 1'b1;
          rd_addr    = addr_of(nb);
          state_next = S_CHK;
        end else begin
          res_root_next   = ra;
          res_status_next = ST_ABSENT;
          state_next      = S_DONE;
        end
      end

      // Merge: aux gets the first root's entry
      S_LA: begin
        aux_next   = rd_data;
        rd_en      = 1'b1;
        rd_addr    = addr_of(nxt);
        state_next = S_LB;
      end

      S_LB: begin
        unique case (link_mode)
          LINK_SIZE: a_under_b = !(aux.size > rd_data.size);
          LINK_RANK: a_under_b = !(aux.rank > rd_data.rank);
          default:   a_under_b = 1'b1;
        endcase
        wr_en = 1'b1;
        if (a_under_b) begin
          nd        = aux;
          nd.parent = nxt;
          wr_addr   = addr_of(ra);
          aux_next  = aux;
          ent_next  = rd_data;
          nxt_next  = nxt;
        end else begin
          nd        = rd_data;
          nd.parent = ra;
          wr_addr   = addr_of(nxt);
          aux_next  = rd_data;
          ent_next  = aux;
          nxt_next  = ra;
        end
        wr_data    = nd;
        state_next = S_LH;
      end

      S_LH: begin
        child_rank = (aux.rank == RANK_MAX) ? RANK_MAX : aux.rank + RANK_W'(1);
        nd         = ent;
        nd.size    = ent.size + aux.size;
        if (child_rank > ent.rank) begin
          nd.rank = child_rank;
        end
        wr_en           = 1'b1;
        wr_addr         = addr_of(nxt);
        wr_data         = nd;
        res_root_next   = nxt;
        res_status_next = ST_OK;
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_root_next   = res_root;
          out_status_next = res_status;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // A find has finished with root fd_root
    if (fd) begin
      unique case (cmd)
        CMD_INSERT: begin
          res_root_next   = fd_root;
          res_status_next = ST_PRESENT;
          state_next      = S_DONE;
        end
        CMD_FIND: begin
          res_root_next   = fd_root;
          res_status_next = ST_OK;
          state_next      = S_DONE;
        end
        CMD_LINK: begin
          if (!side) begin
            ra_next    = fd_root;
            state_next = S_BGO;
          end else if (!la) begin
            res_root_next   = ra;
            res_status_next = ST_ABSENT;
            state_next      = S_DONE;
          end else if (ra == fd_root) begin
            res_root_next   = ra;
            res_status_next = ST_SAME;
            state_next      = S_DONE;
          end else begin
            nxt_next   = fd_root;
            rd_en      = 1'b1;
            rd_addr    = addr_of(ra);
            state_next = S_LA;
          end
        end
        default: state_next = S_DONE;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      link_mode <= LINK_RANK;
      find_mode <= FIND_FULL;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      out_valid <= out_valid_next;
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          CFG_LINK_MODE: link_mode <= cfg.data;
          CFG_FIND_MODE: find_mode <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    na         <= na_next;
    nb         <= nb_next;
    side       <= side_next;
    cur        <= cur_next;
    rt         <= rt_next;
    moved      <= moved_next;
    ent        <= ent_next;
    aux        <= aux_next;
    nxt        <= nxt_next;
    la         <= la_next;
    ra         <= ra_next;
    res_root   <= res_root_next;
    res_status <= res_status_next;
    out_root   <= out_root_next;
    out_status <= out_status_next;
  end

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("sequencer stayed idle after a request transfer");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside the done state");

  a_parent_in_table: assert property (@(posedge clk) disable iff (rst)
    wr_en && wr_data.present |-> node_ok(wr_data.parent))
    else $error("table write with parent outside the table");

  a_merge_distinct: assert property (@(posedge clk) disable iff (rst)
    state == S_LB |-> ra != nxt)
    else $error("merge of a root with itself");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> state == S_CLR && clr_cnt == '0)
    else $error("clearing pass not started after reset");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the union-find engine: predictor, driver, monitor.
`timescale 1ns / 1ps

module tb_top;
  import uf_pkg::*;

  localparam int NODES = NODES_DEFAULT;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 72;
  localparam int MAX_REPORTS = 10;

  // Codes the package leaves unnamed
  localparam cmd_t  CMD_UNUSED = 2'd3;
  localparam mode_t LINK_NAIVE = 2'd2;
  localparam mode_t LINK_ODD   = 2'd3;
  localparam mode_t FIND_NONE  = 2'd2;
  localparam mode_t FIND_ODD   = 2'd3;

  // Chain of singletons merged naively so the top rank saturates
  localparam int CHAIN_BASE = 944;
  localparam int CHAIN_LEN  = 17;

  typedef struct packed {
    cmd_t  command;
    node_t a;
    node_t b;
  } cmd_item_t;

  typedef struct packed {
    node_t   root;
    status_t status;
  } answer_t;

  logic clk;
  logic rst;

  uf_req_if req ();
  uf_rsp_if rsp ();
  uf_cfg_if cfg ();

  union_find_engine #(.NODES(NODES)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // Mirror of the node table and the mode registers
  node_t up_tbl  [NODES];
  size_t cnt_tbl [NODES];
  rank_t rnk_tbl [NODES];
  bit    live_tbl[NODES];
  mode_t link_rule = LINK_RANK;
  mode_t find_rule = FIND_FULL;

  cmd_item_t cmd_queue[$];
  answer_t   due_answers[$];

  // Shared knobs; calm and hold_go are set by the stimulus process
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  bit long_hold;
  int hold_cnt;

  int fails = 0;
  int checked = 0;
  int cmd_seen[4] = '{0, 0, 0, 0};
  int st_seen[4] = '{0, 0, 0, 0};

  mode_t phase_link[PHASES] = '{LINK_SIZE, LINK_RANK, LINK_NAIVE, LINK_ODD, LINK_SIZE,
                                LINK_RANK, LINK_NAIVE, LINK_SIZE, LINK_RANK, LINK_NAIVE};
  mode_t phase_find[PHASES] = '{FIND_FULL, FIND_HALVE, FIND_NONE, FIND_ODD, FIND_HALVE,
                                FIND_NONE, FIND_FULL, FIND_NONE, FIND_FULL, FIND_HALVE};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (live_tbl[i]) live_tbl[i] = 1'b0;
  end

  // Walk to the root without touching the table
  function automatic node_t climb(node_t n);
    int steps = 0;
    while (up_tbl[n] != n && steps < NODES) begin
      n = up_tbl[n];
      steps++;
    end
    return n;
  endfunction

  // Find with the current compression rule applied
  function automatic node_t settle(node_t n);
    node_t top, cur, nxt, p, gp;
    size_t moved, orig;
    int    steps = 0;
    top = climb(n);
    cur = n;
    if (find_rule == FIND_FULL) begin
      moved = cnt_tbl[cur];
      while (cur != top && steps < NODES) begin
        nxt = up_tbl[cur];
        up_tbl[cur] = top;
        if (nxt == top) break;
        orig = cnt_tbl[nxt];
        cnt_tbl[nxt] = orig - moved;
        moved = orig;
        cur = nxt;
        steps++;
      end
    end else if (find_rule == FIND_HALVE) begin
      while (cur != top && steps < NODES) begin
        p = up_tbl[cur];
        if (p == top) break;
        gp = up_tbl[p];
        cnt_tbl[p] = cnt_tbl[p] - cnt_tbl[cur];
        cnt_tbl[gp] = cnt_tbl[gp] + cnt_tbl[cur];
        up_tbl[cur] = gp;
        cur = gp;
        steps++;
      end
    end
    return top;
  endfunction

  // Hang one root under another; rank saturates
  function automatic void graft(node_t child, node_t top);
    rank_t nr;
    nr = (rnk_tbl[child] == RANK_MAX) ? RANK_MAX : rnk_tbl[child] + 1'b1;
    up_tbl[child] = top;
    cnt_tbl[top] = cnt_tbl[top] + cnt_tbl[child];
    if (nr > rnk_tbl[top]) rnk_tbl[top] = nr;
  endfunction

  function automatic answer_t apply_command(cmd_item_t it);
    answer_t ans;
    node_t   ra, rb;
    bit      la, lb, a_low;
    ans.root = '0;
    ans.status = ST_ABSENT;
    ra = '0;
    rb = '0;
    case (it.command)
      CMD_INSERT: begin
        if (live_tbl[it.a]) begin
          ans.root = climb(it.a);
          ans.status = ST_PRESENT;
        end else begin
          live_tbl[it.a] = 1'b1;
          up_tbl[it.a] = it.a;
          cnt_tbl[it.a] = size_t'(1);
          rnk_tbl[it.a] = '0;
          ans.root = it.a;
          ans.status = ST_OK;
        end
      end
      CMD_FIND: begin
        if (live_tbl[it.a]) begin
          ans.root = settle(it.a);
          ans.status = ST_OK;
        end
      end
      CMD_LINK: begin
        la = live_tbl[it.a];
        lb = live_tbl[it.b];
        if (la) ra = settle(it.a);
        if (lb) rb = settle(it.b);
        ans.root = ra;
        if (!(la && lb)) begin
          ans.status = ST_ABSENT;
        end else if (ra == rb) begin
          ans.status = ST_SAME;
        end else begin
          case (link_rule)
            LINK_SIZE: a_low = !(cnt_tbl[ra] > cnt_tbl[rb]);
            LINK_RANK: a_low = !(rnk_tbl[ra] > rnk_tbl[rb]);
            default:   a_low = 1'b1;
          endcase
          if (a_low) begin
            graft(ra, rb);
            ans.root = rb;
          end else begin
            graft(rb, ra);
            ans.root = ra;
          end
          ans.status = ST_OK;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Request driver: random gap after each item, none while calm
  int gap;
  always @(posedge clk) begin
    int        ngap;
    cmd_item_t it;
    if (rst) begin
      req.valid <= 1'b0;
      gap <= 0;
    end else if (!(req.valid && !req.ready)) begin
      ngap = gap;
      if (req.valid) begin
        it.command = req.command;
        it.a = req.node_a;
        it.b = req.node_b;
        due_answers.push_back(apply_command(it));
        cmd_seen[req.command]++;
        ngap = calm ? 0 : $urandom_range(0, 8);
      end
      if (ngap == 0 && cmd_queue.size() > 0) begin
        it = cmd_queue.pop_front();
        req.valid <= 1'b1;
        req.command <= it.command;
        req.node_a <= it.a;
        req.node_b <= it.b;
        gap <= 0;
      end else begin
        req.valid <= 1'b0;
        gap <= (ngap > 0) ? ngap - 1 : 0;
      end
    end
  end

  // One long receiver hold-off so the engine backs up into the request side
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
      long_hold <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      long_hold <= 1'b0;
    end
  end

  // Response monitor: checks each transfer against the oldest prediction
  int stall;
  always @(posedge clk) begin
    int      nstall;
    answer_t exp_ans;
    if (rst) begin
      rsp.ready <= 1'b0;
      stall <= 0;
    end else begin
      nstall = (stall > 0) ? stall - 1 : 0;
      if (rsp.valid && rsp.ready) begin
        checked++;
        st_seen[rsp.status]++;
        if (due_answers.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: unexpected response root %0d status %0d",
                     $time, rsp.root, rsp.status);
        end else begin
          exp_ans = due_answers.pop_front();
          if (rsp.root !== exp_ans.root || rsp.status !== exp_ans.status) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("%0t: mismatch root exp %0d got %0d, status exp %0d got %0d",
                       $time, exp_ans.root, rsp.root, exp_ans.status, rsp.status);
          end
        end
        nstall = calm ? 0 : $urandom_range(0, 8);
      end
      stall <= nstall;
      rsp.ready <= (nstall == 0) && !long_hold;
    end
  end

  function automatic node_t pool_node();
    int idx;
    idx = $urandom_range(0, 95);
    return (idx < 48) ? node_t'(idx) : node_t'(976 + idx - 48);
  endfunction

  function automatic void queue_cmd(cmd_t c, int a, int b);
    cmd_item_t it;
    it.command = c;
    it.a = node_t'(a);
    it.b = node_t'(b);
    cmd_queue.push_back(it);
  endfunction

  // Mostly well-formed traffic on a small node pool, some noise
  function automatic cmd_item_t random_cmd();
    cmd_item_t it;
    int        pick;
    pick = $urandom_range(0, 99);
    it.a = pool_node();
    it.b = pool_node();
    if (pick < 20) begin
      it.command = CMD_INSERT;
    end else if (pick < 60) begin
      it.command = CMD_LINK;
    end else if (pick < 92) begin
      it.command = CMD_FIND;
    end else if (pick < 96) begin
      it.command = CMD_UNUSED;
      it.a = node_t'($urandom);
      it.b = node_t'($urandom);
    end else begin
      it.command = cmd_t'($urandom_range(0, 2));
      it.a = node_t'($urandom);
      it.b = node_t'($urandom);
    end
    return it;
  endfunction

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == CFG_LINK_MODE) link_rule = val;
    else if (idx == CFG_FIND_MODE) find_rule = val;
    @(negedge clk);
  endtask

  // Let every queued command go out and its response come back
  task automatic drain();
    do @(negedge clk); while (cmd_queue.size() > 0 || req.valid || due_answers.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    bit chain_done;
    chain_done = 1'b0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.command = CMD_INSERT;
    req.node_a = '0;
    req.node_b = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_LINK_MODE;
    cfg.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: absent nodes, re-insert, ties, same set, unused command
    queue_cmd(CMD_FIND, 0, 0);
    queue_cmd(CMD_LINK, 0, 1023);
    queue_cmd(CMD_INSERT, 0, 0);
    queue_cmd(CMD_INSERT, 1023, 0);
    queue_cmd(CMD_INSERT, 0, 1023);
    queue_cmd(CMD_LINK, 0, 5);
    queue_cmd(CMD_LINK, 5, 0);
    queue_cmd(CMD_LINK, 0, 1023);
    queue_cmd(CMD_LINK, 1023, 0);
    queue_cmd(CMD_FIND, 0, 0);
    queue_cmd(CMD_UNUSED, 0, 0);
    queue_cmd(CMD_INSERT, 512, 0);
    queue_cmd(CMD_INSERT, 513, 0);
    queue_cmd(CMD_LINK, 512, 513);
    queue_cmd(CMD_LINK, 513, 0);
    queue_cmd(CMD_FIND, 512, 0);
    queue_cmd(CMD_INSERT, 512, 0);
    queue_cmd(CMD_INSERT, 341, 0);
    queue_cmd(CMD_INSERT, 682, 0);
    queue_cmd(CMD_LINK, 341, 682);
    queue_cmd(CMD_FIND, 341, 0);
    queue_cmd(CMD_UNUSED, 1023, 1023);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_LINK_MODE, phase_link[p]);
      write_reg(CFG_FIND_MODE, phase_find[p]);
      calm = (p % 3 == 1) || (p == 3);
      if (p == 3) hold_go = 1'b1;
      if (phase_link[p] == LINK_NAIVE && !chain_done) begin
        for (int i = 0; i < CHAIN_LEN; i++) queue_cmd(CMD_INSERT, CHAIN_BASE + i, 0);
        for (int i = 0; i + 1 < CHAIN_LEN; i++)
          queue_cmd(CMD_LINK, CHAIN_BASE + i, CHAIN_BASE + i + 1);
        queue_cmd(CMD_FIND, CHAIN_BASE, 0);
        chain_done = 1'b1;
      end else if (chain_done) begin
        // tie three pool trees to the saturated chain in every later phase
        repeat (3)
          queue_cmd(CMD_LINK, pool_node(), CHAIN_BASE + $urandom_range(0, CHAIN_LEN - 1));
      end
      repeat (PHASE_ITEMS) cmd_queue.push_back(random_cmd());
      drain();
    end

    calm = 1'b0;
    repeat (30) @(negedge clk);
    fails += due_answers.size();
    $display("Run covered %0d commands (%0d insert, %0d find, %0d link, %0d unused) in %0d modes",
             cmd_seen[0] + cmd_seen[1] + cmd_seen[2] + cmd_seen[3],
             cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], PHASES + 1);
    $display("%0d responses checked: %0d ok, %0d absent, %0d same set, %0d already present",
             checked, st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/uf_pkg.sv
hdl/uf_req_if.sv
hdl/uf_rsp_if.sv
hdl/uf_cfg_if.sv
hdl/union_find_engine.sv
test/tb_top.sv
